>>> src/i2a_pkg.sv
// Package for the integer-to-ASCII formatter: operation codes, queue entry
// type, state enums and the character tables.
// No dependencies.
`default_nettype none

package i2a_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIG_NIBBLES = 16;
	localparam int DEC_DIGITS  = 10;
	localparam int BIN_BITS    = 32;

	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_PTR  = 3'd4;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LPAR  = 8'h28;

	typedef enum logic [1:0] {
		K_NUM,
		K_PTR,
		K_NIL
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        neg;
		logic        upper;
		logic [63:0] digits;   // MSB-aligned nibbles, leading zeros stripped
		logic [4:0]  ndig;
	} entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_STRIP,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PRE,
		B_DIG,
		B_NIL
	} back_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else if (upper) begin
			c = 8'h41 + {4'd0, nib - 4'd10};
		end else begin
			c = 8'h61 + {4'd0, nib - 4'd10};
		end
		return c;
	endfunction

	function automatic logic [7:0] nil_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = CH_LPAR;
			3'd1:    c = 8'h6e;
			3'd2:    c = 8'h69;
			3'd3:    c = 8'h6c;
			default: c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/i2a_front.sv
// Front end: accepts items, classifies the operation and builds the digit
// string (shift-add-3 BCD conversion or hex nibbles, leading zeros stripped).
// Depends on i2a_pkg.
`default_nettype none

module i2a_front
	import i2a_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] value,
	output logic             push,
	output entry_t           push_entry,
	input  wire logic        q_full
);

	front_state_t state_q, state_d;
	logic [63:0]  digits_q;
	logic [4:0]   ndig_q;
	logic [31:0]  bin_q;
	logic [4:0]   cnt_q;
	logic         neg_q;
	logic         upper_q;
	kind_t        kind_q;
	logic         accept;
	logic [31:0]  low;
	logic [31:0]  mag;
	logic [39:0]  bcd_adj;

	function automatic logic [39:0] dabble(input logic [39:0] bcd);
		logic [39:0] r;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			r[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
		end
		return r;
	endfunction

	assign accept  = in_valid && in_ready;
	assign low     = value[31:0];
	assign mag     = (operation == OP_SDEC && low[31]) ? (~low + 32'd1) : low;
	assign bcd_adj = dabble(digits_q[63:24]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (operation == OP_SDEC || operation == OP_UDEC) begin
						state_d = F_CONV;
					end else if (operation == OP_PTR && value == 64'd0) begin
						state_d = F_PUSH;
					end else if (operation == OP_HEXL || operation == OP_HEXU ||
						operation == OP_PTR) begin
						state_d = F_STRIP;
					end
				end
			end
			F_CONV: begin
				if (cnt_q == 5'(BIN_BITS - 1)) state_d = F_STRIP;
			end
			F_STRIP: begin
				if (!(digits_q[63:60] == 4'd0 && ndig_q > 5'd1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		push     = (state_q == F_PUSH) && !q_full;
		push_entry.kind   = kind_q;
		push_entry.neg    = neg_q;
		push_entry.upper  = upper_q;
		push_entry.digits = digits_q;
		push_entry.ndig   = ndig_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					neg_q   <= (operation == OP_SDEC) && low[31];
					upper_q <= (operation == OP_HEXU);
					cnt_q   <= 5'd0;
					bin_q   <= mag;
					if (operation == OP_PTR) begin
						kind_q   <= (value == 64'd0) ? K_NIL : K_PTR;
						digits_q <= value;
						ndig_q   <= 5'(DIG_NIBBLES);
					end else if (operation == OP_HEXL || operation == OP_HEXU) begin
						kind_q   <= K_NUM;
						digits_q <= {low, 32'd0};
						ndig_q   <= 5'd8;
					end else begin
						kind_q   <= K_NUM;
						digits_q <= 64'd0;
						ndig_q   <= 5'(DEC_DIGITS);
					end
				end
			end
			F_CONV: begin
				// BCD digits live in the top 40 bits of the digit register
				digits_q[63:24] <= {bcd_adj[38:0], bin_q[31]};
				bin_q           <= {bin_q[30:0], 1'b0};
				cnt_q           <= cnt_q + 5'd1;
			end
			F_STRIP: begin
				if (digits_q[63:60] == 4'd0 && ndig_q > 5'd1) begin
					digits_q <= {digits_q[59:0], 4'd0};
					ndig_q   <= ndig_q - 5'd1;
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/i2a_queue.sv
// Small FIFO of digit-string entries between the front and back ends.
// Depends on i2a_pkg.
`default_nettype none

module i2a_queue
	import i2a_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	input  wire logic   pop,
	output entry_t      head,
	output logic        empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (pop)  rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

>>> src/i2a_back.sv
// Back end: takes queue entries and emits prefix, digit or (nil) characters one per
// cycle unless stalled, into the output register, with the running character count.
// Depends on i2a_pkg.
`default_nettype none

module i2a_back
	import i2a_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire entry_t head,
	input  wire logic   empty,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [7:0]  character,
	output logic        last,
	output logic [31:0] total_count
);

	back_state_t state_q, state_d;
	kind_t       kind_q;
	logic        upper_q;
	logic [63:0] dig_q;
	logic [4:0]  ndig_q;
	logic [2:0]  idx_q;
	logic        valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic [31:0] count_q;
	logic        advance;
	logic        emit;
	logic [7:0]  emit_char;
	logic        emit_last;

	assign advance = !valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (advance && !empty) begin
					if (head.kind == K_NIL)                     state_d = B_NIL;
					else if (head.kind == K_PTR || head.neg)    state_d = B_PRE;
					else                                        state_d = B_DIG;
				end
			end
			B_NIL: if (advance && idx_q == 3'd4) state_d = B_IDLE;
			B_PRE: if (advance && (kind_q != K_PTR || idx_q == 3'd1)) state_d = B_DIG;
			B_DIG: if (advance && ndig_q == 5'd1) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && advance && !empty;
		emit      = (state_q != B_IDLE) && advance;
		emit_char = hex_char(dig_q[63:60], upper_q);
		emit_last = 1'b0;
		unique case (state_q)
			B_NIL: begin
				emit_char = nil_char(idx_q);
				emit_last = (idx_q == 3'd4);
			end
			B_PRE: begin
				if (kind_q == K_PTR) emit_char = (idx_q == 3'd0) ? CH_ZERO : CH_X;
				else                 emit_char = CH_MINUS;
			end
			B_DIG: emit_last = (ndig_q == 5'd1);
			B_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
			count_q <= 32'd0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				valid_q <= 1'b1;
				count_q <= count_q + 32'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			upper_q <= head.upper;
			dig_q   <= head.digits;
			ndig_q  <= head.ndig;
			idx_q   <= 3'd0;
		end else if (emit) begin
			if (state_q == B_DIG) begin
				dig_q  <= {dig_q[59:0], 4'd0};
				ndig_q <= ndig_q - 5'd1;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid   = valid_q;
	assign character   = char_q;
	assign last        = last_q;
	assign total_count = count_q;

endmodule

`default_nettype wire

>>> src/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter, top level: front end, entry queue, back end.
// Front: accept, BCD conversion for decimal, leading-zero strip, then push to the queue.
// Back: load an entry, then one character per cycle (up to 18), unless stalled, into the output register.
// The front can take a new item once its last entry is in the queue, while the back still emits earlier ones.
// Reset (arst_n low) clears the queue, both state machines and the character count.
`default_nettype none

module integer_to_ascii_formatter
	import i2a_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       character,
	output logic             last,
	output logic [31:0]      total_count
);

	logic   push, pop, q_full, q_empty;
	entry_t push_entry, head;

	i2a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	i2a_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	i2a_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last        (last),
		.total_count (total_count)
	);

endmodule

`default_nettype wire

>>> src/i2a_checker.sv
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// Depends on nothing but the top-level ports.
`default_nettype none

module i2a_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  character,
	input wire logic        last,
	input wire logic [31:0] total_count
);

	logic [31:0] seen_q;
	logic        out_acc;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_q <= 32'd0;
		else if (out_acc) seen_q <= total_count;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled output word changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> total_count == seen_q + 32'd1)
		else $error("character count skipped or repeated");

	a_prefix_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == 8'h2d || character == 8'h28 || character == 8'h78)
		|-> !last)
		else $error("prefix character flagged last");

	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character >= 8'h28 && character <= 8'h78))
		else $error("character outside output alphabet");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.character   (character),
	.last        (last),
	.total_count (total_count)
);

`default_nettype wire

>>> tb/integer_to_ascii_formatter_test.sv
// Testbench for integer_to_ascii_formatter: directed and random format requests,
// random stalls on both channels, and a scoreboard that predicts every output word.
// Depends on i2a_pkg and the integer_to_ascii_formatter RTL.
`default_nettype none

module integer_to_ascii_formatter_test;
	import i2a_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// operation codes the block ignores
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID   = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 180;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic [31:0] count;
	} char_word_t;

	class char_scoreboard;
		char_word_t  pending_chars[$];
		logic [31:0] chars_emitted;
		int          errors;
		string       hex_lo;
		string       hex_up;
		string       nil_text;

		function new();
			chars_emitted = '0;
			errors        = 0;
			hex_lo        = "0123456789abcdef";
			hex_up        = "0123456789ABCDEF";
			nil_text      = "(nil)";
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return pending_chars.size();
		endfunction

		// Build the text for one accepted request and queue one word per character.
		function void note_word(input logic [2:0] op, input logic [63:0] val);
			logic [7:0]  text[$];
			logic [7:0]  digs[$];
			logic [63:0] mag;
			logic [31:0] low;
			int unsigned base;
			string       table_s;
			bit          nil;
			char_word_t  w;
			low     = val[31:0];
			mag     = {32'd0, low};
			base    = 10;
			table_s = hex_lo;
			nil     = 1'b0;
			case (op)
				OP_SDEC: begin
					if (low[31]) begin
						text.push_back(CH_MINUS);
						mag = {32'd0, ~low + 32'd1};
					end
				end
				OP_UDEC: ;
				OP_HEXL: base = 16;
				OP_HEXU: begin
					base    = 16;
					table_s = hex_up;
				end
				OP_PTR: begin
					base = 16;
					mag  = val;
					if (val == 64'd0) begin
						nil = 1'b1;
						for (int i = 0; i < nil_text.len(); i++)
							text.push_back(nil_text[i]);
					end else begin
						text.push_back(CH_ZERO);
						text.push_back(CH_X);
					end
				end
				default: return;
			endcase
			if (!nil) begin
				do begin
					digs.push_front(table_s[int'(mag % base)]);
					mag = mag / base;
				end while (mag != 64'd0);
				text = {text, digs};
			end
			foreach (text[k]) begin
				chars_emitted = chars_emitted + 32'd1;
				w.ch    = text[k];
				w.last  = (k == text.size() - 1);
				w.count = chars_emitted;
				pending_chars.push_back(w);
			end
		endfunction

		task check_word(input logic [7:0] ch, input logic lst, input logic [31:0] cnt);
			char_word_t w;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected word char=%h last=%b count=%0d", ch, lst, cnt));
				return;
			end
			w = pending_chars.pop_front();
			if (ch !== w.ch)
				report($sformatf("char %h, expected %h (count %0d)", ch, w.ch, w.count));
			if (lst !== w.last)
				report($sformatf("last %b, expected %b (count %0d)", lst, w.last, w.count));
			if (cnt !== w.count)
				report($sformatf("total_count %0d, expected %0d", cnt, w.count));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = OP_SDEC;
	logic [63:0] value = 64'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  character;
	logic        last;
	logic [31:0] total_count;

	bit             quiet = 1'b0;
	bit             long_hold_req = 1'b0;
	char_scoreboard sb = new();

	integer_to_ascii_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last),
		.total_count(total_count)
	);

	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 10);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [2:0] op, input logic [63:0] val, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= val;
		do @(posedge clk); while (!in_ready);
		sb.note_word(op, val);
		@(negedge clk);
	endtask

	initial begin : sink
		int stall;
		int hold;
		stall = 0;
		hold  = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(99) < 25) begin
				out_ready <= 1'b0;
				stall = pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_word(character, last, total_count);
		end
	end

	initial begin : stimulus
		logic [2:0]  op;
		logic [63:0] val;
		logic [63:0] full;
		int          n;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes and the special cases of each mode
		send_word(OP_SDEC, 64'd0, 0);
		send_word(OP_SDEC, 64'd1, pick_gap());
		send_word(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
		send_word(OP_SDEC, 64'h0000_0000_7FFF_FFFF, pick_gap());
		send_word(OP_SDEC, 64'h0000_0000_8000_0000, pick_gap());
		send_word(OP_SDEC, 64'hDEAD_BEEF_0000_0005, pick_gap());
		send_word(OP_UDEC, 64'd0, pick_gap());
		send_word(OP_UDEC, 64'h0000_0000_FFFF_FFFF, pick_gap());
		send_word(OP_UDEC, 64'hFFFF_FFFF_8000_0000, pick_gap());
		send_word(OP_HEXL, 64'd0, pick_gap());
		send_word(OP_HEXL, 64'h1234_5678_FFFF_FFFF, pick_gap());
		send_word(OP_HEXL, 64'h0000_0000_0ABC_DEF0, pick_gap());
		send_word(OP_HEXU, 64'hFFFF_FFFF_0000_0000, pick_gap());
		send_word(OP_HEXU, 64'h0000_0000_FEDC_BA98, pick_gap());
		send_word(OP_HEXU, 64'h0000_0000_0000_0001, pick_gap());
		send_word(OP_PTR, 64'd0, pick_gap());
		send_word(OP_PTR, 64'd1, pick_gap());
		send_word(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
		send_word(OP_PTR, 64'h8000_0000_0000_0000, pick_gap());
		send_word(OP_PTR, 64'h0000_0001_0000_0000, pick_gap());
		send_word(OP_SPARE_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
		send_word(OP_SPARE_MID, 64'd0, 0);
		send_word(OP_SPARE_LAST, 64'h0123_4567_89AB_CDEF, pick_gap());
		send_word(OP_SDEC, 64'h0000_0000_8000_0001, 0);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			quiet = (n >= 130 && n < 170);
			if ($urandom_range(99) < 8)
				op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
			else
				op = 3'($urandom_range(OP_PTR, OP_SDEC));
			full = {$urandom, $urandom};
			case ($urandom_range(5))
				0: val = full >> $urandom_range(63, 0);
				1: val = 64'($urandom_range(20));
				2: val = {full[63:32], ~32'($urandom_range(20))};
				3: val = {full[63:32], 32'h8000_0000 | 32'($urandom_range(3))};
				default: val = full;
			endcase
			// sink stops for a long time while the source keeps pushing
			if (n == 60)
				long_hold_req = 1'b1;
			if (n >= 60 && n < 80)
				send_word(op, val, 0);
			else
				send_word(op, val, pick_gap());
			if (op <= OP_PTR)
				n++;
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#15ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
